@@ rtl/tmc_pkg.sv @@
// Shared types and register codes for the truncated multiplier with correction.
package tmc_pkg;

    localparam int OPERAND_PORT_BITS = 8;
    localparam int PRODUCT_PORT_BITS = 8;
    localparam int CFG_DATA_BITS     = 4;
    localparam int HYBRID_MAX        = 15;

    typedef enum logic [0:0] {
        REG_METHOD      = 1'b0,
        REG_HYBRID_BITS = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        METH_NONE     = 2'd0,
        METH_CONSTANT = 2'd1,
        METH_VARIABLE = 2'd2,
        METH_HYBRID   = 2'd3
    } method_t;

    typedef struct packed {
        method_t    method;
        logic [3:0] hybrid_bits;
    } corr_cfg_t;

endpackage

@@ rtl/tmc_datapath.sv @@
// Truncated partial-product sum, correction and saturation, purely combinational.
module tmc_datapath import tmc_pkg::*; #(
    parameter int MULTIPLICAND_BITS = 8,
    parameter int MULTIPLIER_BITS   = 8,
    parameter int PRODUCT_BITS      = 8,
    parameter int KEPT_COLUMNS      = 2
) (
    input  logic [MULTIPLICAND_BITS-1:0] a,
    input  logic [MULTIPLIER_BITS-1:0]   b,
    input  corr_cfg_t                    cfg,
    output logic [PRODUCT_PORT_BITS-1:0] product
);

    localparam int M    = MULTIPLICAND_BITS;
    localparam int N    = MULTIPLIER_BITS;
    localparam int F    = PRODUCT_BITS + KEPT_COLUMNS;
    localparam int D    = M + N - F;
    localparam int SW   = ((F > 7) ? F : 7) + 3;
    localparam int EW   = M + SW;
    localparam int BS   = (N < F) ? N : F - 1;
    localparam int FIRST = N - BS + 1;
    localparam int VCNT = N - FIRST;
    localparam int PL   = (VCNT > HYBRID_MAX + 1) ? VCNT : HYBRID_MAX + 1;
    localparam int CNTW = $clog2(PL + 1);
    localparam int VAR_OFS = (KEPT_COLUMNS >= 1) ? ((1 << (KEPT_COLUMNS - 1)) - 1) : 0;
    localparam logic [SW-1:0] PMAX = SW'((64'd1 << PRODUCT_BITS) - 64'd1);

    // Rounded constant in units of 2^-F, nb quarter units removed; ties to even
    // unless the D-1+2^-D term carries a fraction beyond the tie.
    function automatic int const_part(input int nb);
        int  i4;
        int  fl;
        int  rem;
        int  res;
        bit  extra;
        i4    = 2 * ((1 << KEPT_COLUMNS) - 1) - nb;
        extra = 1'b0;
        if (D >= 1)
        begin
            i4    = i4 + D - 1;
            extra = 1'b1;
        end
        if (i4 >= 0)
            fl = i4 / 4;
        else
            fl = -((-i4 + 3) / 4);
        rem = i4 - 4 * fl;
        res = fl;
        if (rem == 3)
            res = fl + 1;
        else if (rem == 2)
        begin
            if (extra || (fl % 2 != 0))
                res = fl + 1;
        end
        return res;
    endfunction

    logic signed [SW-1:0] const_tab [HYBRID_MAX+1];

    for (genvar g = 0; g <= HYBRID_MAX; g++)
    begin : g_const
        assign const_tab[g] = SW'(const_part(g));
    end

    // ANDed bit pairs of the first discarded column, t = FIRST + k
    logic [PL-1:0] pair;

    for (genvar k = 0; k < PL; k++)
    begin : g_pair
        localparam int T  = FIRST + k;
        localparam int AI = D - 1 - T;
        if (T >= 0 && T < N && AI >= 0 && AI < M)
        begin : g_in
            assign pair[k] = b[T] & a[AI];
        end
        else
        begin : g_out
            assign pair[k] = 1'b0;
        end
    end

    logic [SW-1:0]        psum;
    logic [CNTW-1:0]      vcnt;
    logic [CNTW-1:0]      hcnt;
    logic signed [SW-1:0] corr;
    logic signed [SW-1:0] sum;
    logic [SW-1:0]        mag;
    logic [SW-1:0]        sat;

    always_comb
    begin
        logic [EW-1:0] term;
        psum = '0;
        for (int j = 0; j < N; j++)
        begin
            if (j - D >= 0)
                term = EW'(a) << (j - D);
            else
                term = EW'(a) >> (D - j);
            if (b[j])
                psum = psum + term[SW-1:0];
        end
    end

    always_comb
    begin
        vcnt = '0;
        hcnt = '0;
        for (int k = 0; k < PL; k++)
        begin
            if (k < VCNT)
                vcnt = vcnt + CNTW'(pair[k]);
            if (CNTW'(k) < CNTW'(cfg.hybrid_bits))
                hcnt = hcnt + CNTW'(pair[k]);
        end
    end

    always_comb
    begin
        case (cfg.method)
            METH_NONE:     corr = '0;
            METH_CONSTANT: corr = const_tab[0];
            METH_VARIABLE: corr = SW'(VAR_OFS) + signed'(SW'(vcnt));
            METH_HYBRID:   corr = const_tab[cfg.hybrid_bits] + signed'(SW'(hcnt));
            default:       corr = '0;
        endcase
    end

    always_comb
    begin
        sum = signed'(psum) + corr;
        mag = sum[SW-1] ? '0 : unsigned'(sum);
        mag = mag >> KEPT_COLUMNS;
        sat = (mag > PMAX) ? PMAX : mag;
    end

    assign product = sat[PRODUCT_PORT_BITS-1:0];

endmodule

@@ rtl/truncated_multiplier_corrected.sv @@
// Top level: operand register, correction datapath and product register.
//
//  channel   | signals                           | transfer
//  ----------+-----------------------------------+-------------------------------
//  request   | start, busy, multiplicand,        | edge with start high, busy low
//            | multiplier                        |
//  result    | done, product                     | done high for one cycle
//  config    | wr_en, wr_index, wr_data          | edge with wr_en high
//
// One request per clock. The request edge loads the operand register and the
// next edge loads the product register after one pass of the multiplier array,
// so the product is shown in the following cycle. busy stays low. Reset clears
// the strobes and both configuration registers. The receiver cannot stall; each
// product is shown for exactly one cycle.
module truncated_multiplier_corrected import tmc_pkg::*; #(
    parameter int MULTIPLICAND_BITS = 8,
    parameter int MULTIPLIER_BITS   = 8,
    parameter int PRODUCT_BITS      = 8,
    parameter int KEPT_COLUMNS      = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [OPERAND_PORT_BITS-1:0] multiplicand,
    input  logic [OPERAND_PORT_BITS-1:0] multiplier,
    output logic                         done,
    output logic [PRODUCT_PORT_BITS-1:0] product,
    input  logic                         wr_en,
    input  logic                         wr_index,
    input  logic [CFG_DATA_BITS-1:0]     wr_data
);

    localparam int M = MULTIPLICAND_BITS;
    localparam int N = MULTIPLIER_BITS;

    corr_cfg_t                    cfg_reg;
    logic                         stage_valid_reg;
    logic [M-1:0]                 a_reg;
    logic [N-1:0]                 b_reg;
    logic [M-1:0]                 a_next;
    logic [N-1:0]                 b_next;
    logic                         done_reg;
    logic [PRODUCT_PORT_BITS-1:0] product_reg;
    logic [PRODUCT_PORT_BITS-1:0] product_next;

    // operand bits above the port width read as zero
    for (genvar i = 0; i < M; i++)
    begin : g_a
        if (i < OPERAND_PORT_BITS)
        begin : g_in
            assign a_next[i] = multiplicand[i];
        end
        else
        begin : g_out
            assign a_next[i] = 1'b0;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_b
        if (i < OPERAND_PORT_BITS)
        begin : g_in
            assign b_next[i] = multiplier[i];
        end
        else
        begin : g_out
            assign b_next[i] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.method      <= METH_NONE;
            cfg_reg.hybrid_bits <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                REG_METHOD:      cfg_reg.method      <= method_t'(wr_data[1:0]);
                REG_HYBRID_BITS: cfg_reg.hybrid_bits <= wr_data[3:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= start & ~busy;
            done_reg        <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        if (stage_valid_reg)
            product_reg <= product_next;
    end

    tmc_datapath #(
        .MULTIPLICAND_BITS (MULTIPLICAND_BITS),
        .MULTIPLIER_BITS   (MULTIPLIER_BITS),
        .PRODUCT_BITS      (PRODUCT_BITS),
        .KEPT_COLUMNS      (KEPT_COLUMNS)
    ) u_datapath (
        .a       (a_reg),
        .b       (b_reg),
        .cfg     (cfg_reg),
        .product (product_next)
    );

    assign busy    = 1'b0;
    assign done    = done_reg;
    assign product = product_reg;

endmodule

@@ rtl/tmc_checker.sv @@
// Port-level checks for the truncated multiplier, bound to the top level.
module tmc_checker import tmc_pkg::*; #(
    parameter int PRODUCT_BITS = 8
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [PRODUCT_PORT_BITS-1:0] product
);

    localparam int PB = (PRODUCT_BITS < PRODUCT_PORT_BITS) ? PRODUCT_BITS
                                                           : PRODUCT_PORT_BITS;
    localparam logic [PRODUCT_PORT_BITS-1:0] PMAX =
        PRODUCT_PORT_BITS'((64'd1 << PB) - 64'd1);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_request_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request without product two cycles later");

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("product strobe without a request");

    a_product_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (product <= PMAX))
        else $error("product above saturation value");

endmodule

bind truncated_multiplier_corrected tmc_checker #(
    .PRODUCT_BITS (PRODUCT_BITS)
) u_tmc_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .product (product)
);

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Testbench for the truncated multiplier with selectable correction.
module tb;
    import tmc_pkg::*;

    localparam int A_BITS      = 8;
    localparam int B_BITS      = 8;
    localparam int P_BITS      = 8;
    localparam int K_COLS      = 2;
    localparam int FRAC_BITS   = P_BITS + K_COLS;
    localparam int DROP_BITS   = A_BITS + B_BITS - FRAC_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 4;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [OPERAND_PORT_BITS-1:0] multiplicand;
    logic [OPERAND_PORT_BITS-1:0] multiplier;
    logic                         done;
    logic [PRODUCT_PORT_BITS-1:0] product;
    logic                         wr_en;
    logic                         wr_index;
    logic [CFG_DATA_BITS-1:0]     wr_data;

    method_t    cur_method;
    logic [3:0] cur_hybrid;
    logic [7:0] pending_products[$];
    logic [7:0] expected_product;
    bit         quiet;
    int         errors;
    int         requests_sent;
    int         products_checked;
    int         settings_used;
    int         cycles;

    truncated_multiplier_corrected #(
        .MULTIPLICAND_BITS (A_BITS),
        .MULTIPLIER_BITS   (B_BITS),
        .PRODUCT_BITS      (P_BITS),
        .KEPT_COLUMNS      (K_COLS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .multiplicand (multiplicand),
        .multiplier   (multiplier),
        .done         (done),
        .product      (product),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic bit operand_bit(logic [7:0] v, int idx, int w);
        if (idx < 0 || idx >= w)
            return 1'b0;
        return v[idx];
    endfunction

    // rounded constant, nb quarter units taken off
    function automatic int const_correction(int nb);
        int  i4;
        int  fl;
        int  rem;
        bit  extra;
        i4 = 2 * ((1 << K_COLS) - 1) - nb;
        extra = 1'b0;
        if (DROP_BITS >= 1)
        begin
            i4 += DROP_BITS - 1;
            extra = 1'b1;
        end
        if (i4 >= 0)
            fl = i4 / 4;
        else
            fl = -((-i4 + 3) / 4);
        rem = i4 - 4 * fl;
        if (rem == 3)
            return fl + 1;
        if (rem == 2)
        begin
            if (extra)
                return fl + 1;
            return fl[0] ? fl + 1 : fl;
        end
        return fl;
    endfunction

    function automatic int column_pairs(logic [7:0] a, logic [7:0] b, int first, int count);
        int n;
        n = 0;
        for (int t = first; t < first + count; t++)
            if (operand_bit(b, t, B_BITS) && operand_bit(a, DROP_BITS - 1 - t, A_BITS))
                n++;
        return n;
    endfunction

    function automatic logic [7:0] predict_product(logic [7:0] a, logic [7:0] b);
        longint acc;
        longint corr;
        longint sum;
        longint prod;
        int     sh;
        int     bspan;
        int     first;
        bspan = (B_BITS < FRAC_BITS) ? B_BITS : FRAC_BITS - 1;
        first = B_BITS - bspan + 1;
        acc = 0;
        for (int j = 0; j < B_BITS; j++)
        begin
            if (b[j])
            begin
                sh = FRAC_BITS - A_BITS - B_BITS + j;
                if (sh >= 0)
                    acc += longint'(a) << sh;
                else
                    acc += longint'(a) >> (-sh);
            end
        end
        case (cur_method)
            METH_CONSTANT: corr = const_correction(0);
            METH_VARIABLE:
            begin
                corr = (K_COLS >= 1) ? ((1 << (K_COLS - 1)) - 1) : 0;
                corr += column_pairs(a, b, first, B_BITS - first);
            end
            METH_HYBRID:
                corr = const_correction(int'(cur_hybrid))
                     + column_pairs(a, b, first, int'(cur_hybrid));
            default: corr = 0;
        endcase
        sum = acc + corr;
        if (sum < 0)
            sum = 0;
        prod = sum >> K_COLS;
        if (prod > (1 << P_BITS) - 1)
            prod = (1 << P_BITS) - 1;
        return prod[7:0];
    endfunction

    task automatic send_request(input logic [7:0] a, input logic [7:0] b);
        int gap;
        start        <= 1'b1;
        multiplicand <= a;
        multiplier   <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_products.push_back(predict_product(a, b));
        requests_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [3:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_METHOD)
            cur_method = method_t'(data[1:0]);
        else
            cur_hybrid = data;
        settings_used++;
    endtask

    task automatic set_config(input method_t m, input logic [3:0] hb, input logic [1:0] junk);
        drain();
        write_reg(REG_METHOD, {junk, m});
        write_reg(REG_HYBRID_BITS, hb);
    endtask

    function automatic logic [7:0] random_operand;
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01 << $urandom_range(0, 7);
            3: return ~(8'h01 << $urandom_range(0, 7));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic directed_operands;
        send_request(8'h00, 8'h00);
        send_request(8'hFF, 8'hFF);
        send_request(8'hFF, 8'h00);
        send_request(8'h00, 8'hFF);
        send_request(8'h3F, 8'hFE);
        send_request(8'h80, 8'h01);
    endtask

    // registers at reset value: no correction
    task automatic test_reset_state;
        directed_operands();
    endtask

    task automatic test_each_method;
        set_config(METH_CONSTANT, 4'd0, 2'b00);
        directed_operands();
        set_config(METH_VARIABLE, 4'd0, 2'b00);
        directed_operands();
        set_config(METH_HYBRID, 4'd8, 2'b00);
        directed_operands();
    endtask

    // hybrid count past the column, zero and all-ones operands: with zero operands the negative sum clamps to zero
    task automatic test_hybrid_overrun;
        set_config(METH_HYBRID, 4'd15, 2'b00);
        send_request(8'h00, 8'h00);
        send_request(8'hFF, 8'hFF);
    endtask

    task automatic test_random;
        method_t    m;
        logic [3:0] hb;
        int         n;
        for (int ph = 0; ph < 20; ph++)
        begin
            m  = method_t'($urandom_range(0, 3));
            if (ph == 0)
                hb = 4'd0;
            else if (ph == 1)
                hb = 4'd15;
            else
                hb = 4'($urandom_range(0, 15));
            if (ph < 2)
                m = METH_HYBRID;
            quiet = (ph >= 18);
            set_config(m, hb, 2'($urandom_range(0, 3)));
            n = $urandom_range(80, 120);
            for (int i = 0; i < n; i++)
                send_request(random_operand(), random_operand());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_products.size() == 0)
            begin
                $error("product: expected none, got %0h", product);
                errors++;
            end
            else
            begin
                expected_product = pending_products.pop_front();
                if (product !== expected_product)
                begin
                    $error("product: expected %0h, got %0h", expected_product, product);
                    errors++;
                end
                products_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** truncated_multiplier_corrected: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        multiplicand <= '0;
        multiplier   <= '0;
        wr_en        <= 1'b0;
        wr_index     <= REG_METHOD;
        wr_data      <= '0;
        cur_method    = METH_NONE;
        cur_hybrid    = 4'd0;
        quiet         = 1'b0;
        errors        = 0;
        requests_sent = 0;
        products_checked = 0;
        settings_used = 0;
        cycles        = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_each_method();
        test_hybrid_overrun();
        test_random();

        drain();
        $display("%0d requests, %0d products checked, %0d register writes",
                 requests_sent, products_checked, settings_used);
        $display("covered all four correction methods, hybrid counts 0, 8, 15 and random");
        if (errors == 0)
            $display("** truncated_multiplier_corrected: PASSED **");
        else
            $display("** truncated_multiplier_corrected: FAILED **");
        $finish;
    end

endmodule
